// ----- src/grpsb_pkg.sv -----
`timescale 1ns / 1ps

package grpsb_pkg;

	localparam int MAX_QUEUE = 16;
	localparam int NUM_SUBS  = 8;
	localparam int MSG_W     = 64;

	localparam int DEPTH_W   = 5;
	localparam int RING_AW   = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;
	localparam int SUB_AW    = (NUM_SUBS > 1) ? $clog2(NUM_SUBS) : 1;

	// remainder unit: bits of the dividend retired per cycle, and steps per job
	localparam int REM_BITS  = 8;
	localparam int REM_STEPS = 32 / REM_BITS;
	localparam int REM_CW    = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;

	localparam logic [2:0] CMD_PUBLISH = 3'd0;
	localparam logic [2:0] CMD_READ    = 3'd1;
	localparam logic [2:0] CMD_QUERY   = 3'd2;
	localparam logic [2:0] CMD_OPEN    = 3'd3;
	localparam logic [2:0] CMD_SET_IV  = 3'd4;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  subscriber;
		logic [63:0] payload;
		logic [31:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [63:0] message_out;
		logic        updated;
		logic [31:0] published_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] gen;
		logic [31:0] interval;
		logic [31:0] last_read;
	} sub_entry_t;

	typedef struct packed {
		logic              en;
		logic [SUB_AW-1:0] addr;
		sub_entry_t        data;
	} sub_wr_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [MSG_W-1:0]   data;
	} ring_wr_t;

	// clamp the configured depth to 1..MAX_QUEUE
	function automatic logic [DEPTH_W-1:0] depth_of(input logic [DEPTH_W-1:0] q);
		logic [DEPTH_W-1:0] d;
		d = q;
		if (q == '0) d = DEPTH_W'(1);
		else if (32'(q) > MAX_QUEUE) d = DEPTH_W'(MAX_QUEUE);
		return d;
	endfunction

endpackage

// ----- src/generation_ring_pubsub_buffer.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// ------    -------------------------  ------------------------------------
// in        in_valid / in_ready        in_data  (cmd, subscriber, payload, now_time)
// out       out_valid / out_ready      out_data (status, message_out, updated,
//                                                published_count)
// cfg       cfg_valid / cfg_ready      cfg_data (queue_depth, 5 bits)
//
// One item is in work at a time. Query, open, set interval, ignored commands
// and a read before any publish pass through the subscriber lookup and finish;
// publish also waits on the four-step remainder unit (generation mod depth,
// 8 bits a cycle), and read on the adjust step, that unit and the registered ring read.
// Reset clears the generation counter, the data flag, the subscriber valid
// bits and the handshakes; queue_depth resets to 1. Ring slots are undefined.
// A finished result waits in the output register while the next item is
// accepted; the item after that holds in its last state until out frees up.
module generation_ring_pubsub_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  grpsb_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output grpsb_pkg::out_item_t          out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [grpsb_pkg::DEPTH_W-1:0] cfg_data
);
	import grpsb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB  = 3'd1;
	localparam logic [2:0] ST_ADJ  = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_RING = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]         state_q;
	logic [DEPTH_W-1:0] qdepth_q;
	logic [31:0]        pub_count_q;
	logic               has_data_q;
	in_item_t           item_q;
	sub_entry_t         entry_q;
	logic [31:0]        gen1_q;
	logic               res_status_q;
	logic [MSG_W-1:0]   res_msg_q;
	logic               res_upd_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               in_fire;
	logic               out_free;
	logic [DEPTH_W-1:0] depth;
	logic [31:0]        d32;
	logic               sub_ok;
	sub_entry_t         entry;
	logic [31:0]        gen_sum;
	logic [31:0]        gen1;
	logic [31:0]        g2;
	logic [31:0]        gnext;
	logic [31:0]        elapsed;
	logic               held;
	logic [31:0]        open_gen;

	sub_wr_t            sub_wr;
	ring_wr_t           ring_wr;
	logic               ring_rd_en;
	logic [MSG_W-1:0]   ring_rd_data;
	logic               rem_start;
	logic [31:0]        rem_dividend;
	logic               rem_done;
	logic [DEPTH_W-1:0] rem;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign depth  = depth_of(qdepth_q);
	assign d32    = 32'(depth);
	assign sub_ok = (32'(item_q.subscriber) < NUM_SUBS);

	grpsb_sub_mem u_sub_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_data.subscriber[SUB_AW-1:0]),
		.rd_data (entry),
		.wr      (sub_wr)
	);

	grpsb_ring u_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd_en   (ring_rd_en),
		.rd_addr (rem[RING_AW-1:0]),
		.rd_data (ring_rd_data)
	);

	grpsb_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (depth),
		.done     (rem_done),
		.rem      (rem)
	);

	// generation arithmetic, all modulo 2^32
	always_comb begin
		// jump forward when more than depth generations behind
		gen_sum  = entry.gen + d32;
		gen1     = (pub_count_q > gen_sum) ? pub_count_q - d32 : entry.gen;
		// nothing new: step back to repeat the latest message
		g2       = (pub_count_q == gen1_q && gen1_q != 32'd0) ? gen1_q - 32'd1 : gen1_q;
		gnext    = (g2 < pub_count_q) ? g2 + 32'd1 : g2;
		elapsed  = item_q.now_time - entry.last_read;
		held     = (entry.interval != 32'd0) && (elapsed < entry.interval);
		open_gen = pub_count_q - ((d32 < pub_count_q) ? d32 : pub_count_q);
	end

	// memory and remainder-unit controls
	always_comb begin
		sub_wr      = '0;
		sub_wr.addr = item_q.subscriber[SUB_AW-1:0];
		if (state_q == ST_SUB && sub_ok) begin
			case (item_q.cmd)
				CMD_OPEN: begin
					sub_wr.en             = 1'b1;
					sub_wr.data.gen       = open_gen;
					sub_wr.data.interval  = 32'd0;
					sub_wr.data.last_read = 32'd0;
				end
				CMD_SET_IV: begin
					sub_wr.en            = 1'b1;
					sub_wr.data          = entry;
					sub_wr.data.interval = item_q.payload[31:0];
				end
				default: ;
			endcase
		end else if (state_q == ST_ADJ) begin
			// advance the reader and stamp the read time when an interval is set
			sub_wr.en       = 1'b1;
			sub_wr.data     = entry_q;
			sub_wr.data.gen = gnext;
			if (entry_q.interval != 32'd0) sub_wr.data.last_read = item_q.now_time;
		end

		rem_start    = (state_q == ST_SUB && item_q.cmd == CMD_PUBLISH) || state_q == ST_ADJ;
		rem_dividend = (state_q == ST_SUB) ? pub_count_q : g2;

		ring_wr.en   = (state_q == ST_MOD) && rem_done && (item_q.cmd == CMD_PUBLISH);
		ring_wr.addr = rem[RING_AW-1:0];
		ring_wr.data = item_q.payload[MSG_W-1:0];
		ring_rd_en   = (state_q == ST_MOD) && rem_done && (item_q.cmd == CMD_READ);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qdepth_q    <= DEPTH_W'(1);
			pub_count_q <= '0;
			has_data_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) qdepth_q <= cfg_data;
			// raise valid as a result moves in, drop it once the item is taken
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (item_q.cmd == CMD_PUBLISH) state_q <= ST_MOD;
					else if (item_q.cmd == CMD_READ && sub_ok && has_data_q) state_q <= ST_ADJ;
					else state_q <= ST_FIN;
				end
				ST_ADJ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (rem_done) begin
						if (item_q.cmd == CMD_PUBLISH) begin
							pub_count_q <= pub_count_q + 32'd1;
							has_data_q  <= 1'b1;
							state_q     <= ST_FIN;
						end else begin
							state_q <= ST_RING;
						end
					end
				end
				ST_RING: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register frees up
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_data;
		case (state_q)
			ST_SUB: begin
				entry_q      <= entry;
				gen1_q       <= gen1;
				res_msg_q    <= '0;
				res_status_q <= sub_ok && !has_data_q &&
					(item_q.cmd == CMD_READ || item_q.cmd == CMD_QUERY);
				res_upd_q    <= sub_ok && has_data_q && (item_q.cmd == CMD_QUERY) &&
					!held && (entry.gen != pub_count_q);
			end
			ST_RING: begin
				res_msg_q <= ring_rd_data;
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.status          <= res_status_q;
					out_q.message_out     <= 64'(res_msg_q);
					out_q.updated         <= res_upd_q;
					out_q.published_count <= pub_count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- src/grpsb_rem.sv -----
`timescale 1ns / 1ps

module grpsb_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    dividend,
	input  logic [grpsb_pkg::DEPTH_W-1:0]  divisor,
	output logic                           done,
	output logic [grpsb_pkg::DEPTH_W-1:0]  rem
);
	import grpsb_pkg::*;

	logic [31:0]        x_q;
	logic [DEPTH_W-1:0] r_q;
	logic [REM_CW-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DEPTH_W:0]   t;
	logic [DEPTH_W-1:0] r_next;

	// restoring remainder, one dividend bit per inner step
	always_comb begin
		r_next = r_q;
		t = '0;
		for (int i = 0; i < REM_BITS; i++) begin
			t = {r_next, x_q[31 - i]};
			if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
			r_next = t[DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse done for one cycle after the last step
			done_q <= !start && busy_q && (cnt_q == REM_CW'(REM_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + REM_CW'(1);
				if (cnt_q == REM_CW'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << REM_BITS;
			r_q <= r_next;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// ----- src/grpsb_sub_mem.sv -----
`timescale 1ns / 1ps

module grpsb_sub_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [grpsb_pkg::SUB_AW-1:0]  rd_addr,
	output grpsb_pkg::sub_entry_t         rd_data,
	input  grpsb_pkg::sub_wr_t            wr
);
	import grpsb_pkg::*;

	sub_entry_t          mem_q [NUM_SUBS];
	logic [NUM_SUBS-1:0] valid_q;
	sub_entry_t          rd_data_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) mem_q[wr.addr] <= wr.data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) valid_q[wr.addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	// an entry never written reads as its reset value
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- src/grpsb_ring.sv -----
`timescale 1ns / 1ps

module grpsb_ring (
	input  logic                           clk,
	input  grpsb_pkg::ring_wr_t            wr,
	input  logic                           rd_en,
	input  logic [grpsb_pkg::RING_AW-1:0]  rd_addr,
	output logic [grpsb_pkg::MSG_W-1:0]    rd_data
);
	import grpsb_pkg::*;

	logic [MSG_W-1:0] mem_q [MAX_QUEUE];
	logic [MSG_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) mem_q[wr.addr] <= wr.data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
